// ===== sv/lca_pkg.sv =====
// shared types, constants and helpers for the lowest common ancestor engine
// no dependencies; imported by lca_ctrl, lca_dpath and lca_binary_lifting_engine
package lca_pkg;

    // tree size and lifting depth
    localparam int MAX_NODES   = 1024;
    localparam int JUMP_LEVELS = 10;

    // field widths
    localparam int NODE_W   = 11;
    localparam int LEVEL_W  = 10;
    localparam int IDX_W    = $clog2(MAX_NODES);
    localparam int K_W      = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int KC_W     = $clog2(JUMP_LEVELS + 1);
    localparam int JADDR_W  = IDX_W + K_W;
    localparam int JMP_DEPTH = MAX_NODES << K_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1023);
    localparam logic [K_W-1:0]     K_TOP     = K_W'(JUMP_LEVELS - 1);
    localparam logic [KC_W-1:0]    K_END     = KC_W'(JUMP_LEVELS);

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [LEVEL_W-1:0] t_level;

    // level memory read address select
    typedef enum logic [1:0] {LV_A, LV_B, LV_CV} t_lvl_sel;

    // jump memory write data select
    typedef enum logic [1:0] {JW_B, JW_ZERO, JW_RD} t_jw_sel;

    // jump memory read address select
    typedef enum logic {JR_LOAD, JR_CLIMB} t_jr_sel;

    // climb start source
    typedef enum logic [1:0] {CS_NONE, CS_A_MID, CS_B_MID, CS_A_HI} t_cl_start;

    // controller to datapath commands
    typedef struct packed {
        logic      accept;
        logic      lvl_rd;
        t_lvl_sel  lvl_sel;
        logic      lvl_wr;
        logic      lvl_inc;
        logic      jw;
        logic      jw_row0;
        t_jw_sel   jw_sel;
        logic      jr;
        t_jr_sel   jr_sel;
        logic      k_init;
        logic      k_inc;
        logic      cur_load;
        logic      la_load;
        logic      q_setup;
        logic      eq_done;
        logic      hi_load;
        t_cl_start cl_start;
        logic      cl_dec;
        logic      cl_jump;
        logic      srch_upd;
        logic      cv_clear;
        logic      out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_query;
        logic ld_bad;
        logic q_bad;
        logic b_zero;
        logic row_done;
        logic cur_zero;
        logic cl_stop;
        logic cl_take;
        logic ck_zero;
        logic lo_lt_hi;
        logic out_free;
    } t_status;

    // node number in 1..MAX_NODES
    function automatic logic node_ok(t_node v);
        return (v != '0) && (v <= NODE_W'(MAX_NODES));
    endfunction

    // memory row of a node
    function automatic logic [IDX_W-1:0] node_idx(t_node v);
        t_node d;
        d = v - NODE_W'(1);
        return d[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/lca_dpath.sv =====
// datapath: jump table and level memories, climb registers, search bounds, output register
// depends on lca_pkg; driven by commands from lca_ctrl
module lca_dpath import lca_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  logic    i_func,
    input  t_node   i_node_a,
    input  t_node   i_node_b,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_node   o_ancestor
);

    // item and working registers
    logic           r_func;
    t_node          r_a;
    t_node          r_b;
    t_level         r_la;
    t_level         r_lo;
    t_level         r_hi;
    t_node          r_cv;
    t_level         r_cd;
    logic [K_W-1:0] r_ck;
    t_node          r_ca;
    t_node          r_cur;
    logic [KC_W-1:0] r_k;
    t_level         r_lvl_rd;
    t_node          r_jmp_rd;
    logic           r_out_valid;
    t_node          r_ancestor;

    // memories
    t_level r_lvl_mem [MAX_NODES];
    t_node  r_jmp_mem [JMP_DEPTH];

    logic [LEVEL_W:0]    mid_sum;
    t_level              mid;
    t_level              step;
    logic [LEVEL_W:0]    lvl_inc_sum;
    t_level              lvl_wdata;
    logic [IDX_W-1:0]    lvl_raddr;
    logic [KC_W-1:0]     kprev;
    logic [K_W-1:0]      jw_k;
    logic [JADDR_W-1:0]  jw_addr;
    logic [JADDR_W-1:0]  jr_addr;
    t_node               jw_data;
    logic                la_lt;

    // search midpoint and climb step
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[LEVEL_W:1];
    assign step    = LEVEL_W'(1) << r_ck;
    assign la_lt   = r_la < r_lvl_rd;

    // saturating level of a child
    assign lvl_inc_sum = {1'b0, r_lvl_rd} + (LEVEL_W+1)'(1);
    assign lvl_wdata   = !i_cmd.lvl_inc ? '0 :
                         (lvl_inc_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX :
                         lvl_inc_sum[LEVEL_W-1:0];

    // level read address
    always_comb begin
        unique case (i_cmd.lvl_sel)
            LV_A:    lvl_raddr = node_idx(r_a);
            LV_B:    lvl_raddr = node_idx(r_b);
            LV_CV:   lvl_raddr = node_idx(r_cv);
            default: lvl_raddr = node_idx(r_a);
        endcase
    end

    // jump table write port
    assign kprev   = r_k - KC_W'(1);
    assign jw_k    = i_cmd.jw_row0 ? '0 : r_k[K_W-1:0];
    assign jw_addr = {node_idx(r_a), jw_k};

    always_comb begin
        unique case (i_cmd.jw_sel)
            JW_B:    jw_data = r_b;
            JW_ZERO: jw_data = '0;
            JW_RD:   jw_data = r_jmp_rd;
            default: jw_data = '0;
        endcase
    end

    // jump table read port
    always_comb begin
        unique case (i_cmd.jr_sel)
            JR_LOAD:  jr_addr = {node_idx(r_cur), kprev[K_W-1:0]};
            JR_CLIMB: jr_addr = {node_idx(r_cv), r_ck};
            default:  jr_addr = {node_idx(r_cv), r_ck};
        endcase
    end

    // level memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.lvl_wr) begin
            r_lvl_mem[node_idx(r_a)] <= lvl_wdata;
        end
        if (i_cmd.lvl_rd) begin
            r_lvl_rd <= r_lvl_mem[lvl_raddr];
        end
    end

    // jump table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.jw) begin
            r_jmp_mem[jw_addr] <= jw_data;
        end
        if (i_cmd.jr) begin
            r_jmp_rd <= r_jmp_mem[jr_addr];
        end
    end

    // item capture and load row chain
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_a    <= i_node_a;
            r_b    <= i_node_b;
        end else begin
            if (i_cmd.q_setup && la_lt) begin
                r_b <= r_a;
            end
            if (i_cmd.eq_done) begin
                r_a <= r_cv;
            end
        end
        if (i_cmd.k_init) begin
            r_k   <= KC_W'(1);
            r_cur <= r_b;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + KC_W'(1);
            end
            if (i_cmd.cur_load) begin
                r_cur <= r_jmp_rd;
            end
        end
    end

    // search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.la_load) begin
            r_la <= r_lvl_rd;
        end
        if (i_cmd.eq_done) begin
            r_lo <= '0;
        end else if (i_cmd.srch_upd && (r_ca != r_cv)) begin
            r_lo <= mid + LEVEL_W'(1);
        end
        if (i_cmd.hi_load) begin
            r_hi <= (r_a == '0) ? '0 : r_lvl_rd;
        end else if (i_cmd.srch_upd && (r_ca == r_cv)) begin
            r_hi <= mid;
        end
    end

    // climb unit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_setup) begin
            r_ck <= K_TOP;
            if (la_lt) begin
                r_cv <= r_b;
                r_cd <= r_lvl_rd - r_la;
            end else begin
                r_cv <= r_a;
                r_cd <= r_la - r_lvl_rd;
            end
        end else if (i_cmd.cl_start != CS_NONE) begin
            r_ck <= K_TOP;
            case (i_cmd.cl_start)
                CS_A_MID: begin
                    r_cv <= r_a;
                    r_cd <= mid;
                end
                CS_B_MID: begin
                    r_ca <= r_cv;
                    r_cv <= r_b;
                    r_cd <= mid;
                end
                default: begin
                    r_cv <= r_a;
                    r_cd <= r_hi;
                end
            endcase
        end else if (i_cmd.cl_jump) begin
            r_cv <= r_jmp_rd;
            r_cd <= r_cd - step;
            if ((r_ck != K_TOP) && (r_ck != '0)) begin
                r_ck <= r_ck - K_W'(1);
            end
        end else if (i_cmd.cl_dec) begin
            r_ck <= r_ck - K_W'(1);
        end else if (i_cmd.cv_clear) begin
            r_cv <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ancestor <= r_cv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_ancestor;

    // status to controller
    always_comb begin
        o_status.is_query = (r_func == FUNC_QUERY);
        o_status.ld_bad   = !node_ok(r_a) || (r_b > NODE_W'(MAX_NODES));
        o_status.q_bad    = !node_ok(r_a) || !node_ok(r_b);
        o_status.b_zero   = (r_b == '0);
        o_status.row_done = (r_k == K_END);
        o_status.cur_zero = (r_cur == '0);
        o_status.cl_stop  = (r_cv == '0) || (r_cd == '0);
        o_status.cl_take  = ((r_cd >> r_ck) != '0);
        o_status.ck_zero  = (r_ck == '0);
        o_status.lo_lt_hi = (r_lo < r_hi);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

endmodule

// ===== sv/lca_ctrl.sv =====
// controller: sequences loads, level equalization, the lift-distance search and climbs
// depends on lca_pkg; drives lca_dpath through t_cmd and reads t_status
module lca_ctrl import lca_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DISPATCH = 13'b0000000000010,
        S_LD_LV    = 13'b0000000000100,
        S_LD_ROW   = 13'b0000000001000,
        S_LD_WAIT  = 13'b0000000010000,
        S_Q_LA     = 13'b0000000100000,
        S_Q_LB     = 13'b0000001000000,
        S_Q_LH     = 13'b0000010000000,
        S_SRCH     = 13'b0000100000000,
        S_CL_STEP  = 13'b0001000000000,
        S_CL_WAIT  = 13'b0010000000000,
        S_NEXT     = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    // what the running climb is for
    typedef enum logic [3:0] {
        PH_EQ  = 4'b0001,
        PH_SA  = 4'b0010,
        PH_SB  = 4'b0100,
        PH_FIN = 4'b1000
    } t_phase;

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_EQ;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.is_query) begin
                    if (i_status.q_bad) begin
                        o_cmd.cv_clear = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.lvl_rd  = 1'b1;
                        o_cmd.lvl_sel = LV_A;
                        n_state       = S_Q_LA;
                    end
                end else if (i_status.ld_bad) begin
                    n_state = S_IDLE;
                end else if (i_status.b_zero) begin
                    // root: level zero, row 0 gets no parent
                    o_cmd.lvl_wr  = 1'b1;
                    o_cmd.jw      = 1'b1;
                    o_cmd.jw_row0 = 1'b1;
                    o_cmd.jw_sel  = JW_B;
                    o_cmd.k_init  = 1'b1;
                    n_state       = S_LD_ROW;
                end else begin
                    o_cmd.lvl_rd  = 1'b1;
                    o_cmd.lvl_sel = LV_B;
                    n_state       = S_LD_LV;
                end
            end
            S_LD_LV: begin
                o_cmd.lvl_wr  = 1'b1;
                o_cmd.lvl_inc = 1'b1;
                o_cmd.jw      = 1'b1;
                o_cmd.jw_row0 = 1'b1;
                o_cmd.jw_sel  = JW_B;
                o_cmd.k_init  = 1'b1;
                n_state       = S_LD_ROW;
            end
            S_LD_ROW: begin
                if (i_status.row_done) begin
                    n_state = S_IDLE;
                end else if (i_status.cur_zero) begin
                    o_cmd.jw     = 1'b1;
                    o_cmd.jw_sel = JW_ZERO;
                    o_cmd.k_inc  = 1'b1;
                end else begin
                    o_cmd.jr     = 1'b1;
                    o_cmd.jr_sel = JR_LOAD;
                    n_state      = S_LD_WAIT;
                end
            end
            S_LD_WAIT: begin
                o_cmd.jw       = 1'b1;
                o_cmd.jw_sel   = JW_RD;
                o_cmd.cur_load = 1'b1;
                o_cmd.k_inc    = 1'b1;
                n_state        = S_LD_ROW;
            end
            S_Q_LA: begin
                o_cmd.la_load = 1'b1;
                o_cmd.lvl_rd  = 1'b1;
                o_cmd.lvl_sel = LV_B;
                n_state       = S_Q_LB;
            end
            S_Q_LB: begin
                // order by depth and lift the deeper node
                o_cmd.q_setup = 1'b1;
                n_phase       = PH_EQ;
                n_state       = S_CL_STEP;
            end
            S_Q_LH: begin
                o_cmd.hi_load = 1'b1;
                n_state       = S_SRCH;
            end
            S_SRCH: begin
                if (i_status.lo_lt_hi) begin
                    o_cmd.cl_start = CS_A_MID;
                    n_phase        = PH_SA;
                end else begin
                    o_cmd.cl_start = CS_A_HI;
                    n_phase        = PH_FIN;
                end
                n_state = S_CL_STEP;
            end
            S_CL_STEP: begin
                if (i_status.cl_stop) begin
                    n_state = S_NEXT;
                end else if (i_status.cl_take) begin
                    o_cmd.jr     = 1'b1;
                    o_cmd.jr_sel = JR_CLIMB;
                    n_state      = S_CL_WAIT;
                end else if (i_status.ck_zero) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.cl_dec = 1'b1;
                end
            end
            S_CL_WAIT: begin
                o_cmd.cl_jump = 1'b1;
                n_state       = S_CL_STEP;
            end
            S_NEXT: begin
                unique case (r_phase)
                    PH_EQ: begin
                        o_cmd.eq_done = 1'b1;
                        o_cmd.lvl_rd  = 1'b1;
                        o_cmd.lvl_sel = LV_CV;
                        n_state       = S_Q_LH;
                    end
                    PH_SA: begin
                        o_cmd.cl_start = CS_B_MID;
                        n_phase        = PH_SB;
                        n_state        = S_CL_STEP;
                    end
                    PH_SB: begin
                        o_cmd.srch_upd = 1'b1;
                        n_state        = S_SRCH;
                    end
                    PH_FIN: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lca_binary_lifting_engine.sv =====
// load: an ignored item returns to idle; else the level and jump row 0 are written, then each upper row
// from the rows above; query: read both levels, lift the deeper node, binary search the lift distance
// (at most 10 search steps, two climbs each), then one final climb; a climb jumps from the top row down
// one item at a time; a finished result waits in an output register while the next item runs
// synchronous active-low reset clears the controller and output valid; memories are not cleared
// top level: joins lca_ctrl and lca_dpath, depends on lca_pkg
module lca_binary_lifting_engine import lca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_func,
    input  t_node i_node_a,
    input  t_node i_node_b,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_node o_ancestor
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    lca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // tables and working registers
    lca_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (i_func),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_ancestor  (o_ancestor)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for lca_binary_lifting_engine: builds random forests and deep chains,
// predicts each lowest common ancestor from its own lifting table and checks every result item
// depends on lca_pkg and the engine rtl only
module tb;
    import lca_pkg::*;

    // one query waiting for its result
    typedef struct {
        t_node node_a;
        t_node node_b;
        t_node ancestor;
    } t_pending;

    localparam int NODE_TOP  = (1 << NODE_W) - 1;
    localparam int LONG_HOLD = 1500;
    localparam int CHAIN_LEN = 600;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    logic  i_func;
    t_node i_node_a;
    t_node i_node_b;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_node o_ancestor;

    // predicted tree: 2^k ancestors and level per node
    t_node    up_tab    [1:MAX_NODES][0:JUMP_LEVELS-1];
    t_level   depth_tab [1:MAX_NODES];
    bit       is_loaded [1:MAX_NODES];
    t_node    loaded_list[$];
    t_pending lca_expected[$];

    int err_count;
    bit burst_mode;
    bit stall_req;
    bit stall_taken;
    int stall_left;
    int ready_gap;

    lca_binary_lifting_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ancestor  (o_ancestor)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic bit node_in_range(t_node v);
        return (v >= 1) && (v <= MAX_NODES);
    endfunction

    function automatic t_node ancestor_at(t_node v, int k);
        if (!node_in_range(v) || k >= JUMP_LEVELS) return '0;
        return up_tab[v][k];
    endfunction

    function automatic int depth_of(t_node v);
        if (!node_in_range(v)) return 0;
        return int'(depth_tab[v]);
    endfunction

    // walk up span levels; the top jump repeats, lower jumps are used at most once
    function automatic t_node lift(t_node v, int span);
        t_node cur;
        int    k;
        int    step;
        bit    stepped;
        bit    stop;
        cur  = v;
        stop = 1'b0;
        for (k = JUMP_LEVELS - 1; k >= 0; k--) begin
            if (!stop) begin
                step    = 1 << k;
                stepped = 1'b0;
                while (span >= step && cur != '0 && (k == JUMP_LEVELS - 1 || !stepped)) begin
                    cur     = ancestor_at(cur, k);
                    span    = span - step;
                    stepped = 1'b1;
                end
                if (cur == '0 || span == 0) stop = 1'b1;
            end
        end
        return cur;
    endfunction

    // load: level from parent, jump row from the rows above
    function automatic void record_node(t_node na, t_node nb);
        int    lv;
        int    k;
        t_node mid;
        if (node_in_range(na) && nb <= MAX_NODES) begin
            lv = (nb == '0) ? 0 : depth_of(nb) + 1;
            if (lv > int'(LEVEL_MAX)) lv = int'(LEVEL_MAX);
            depth_tab[na] = t_level'(lv);
            up_tab[na][0] = nb;
            for (k = 1; k < JUMP_LEVELS; k++) begin
                mid = up_tab[na][k-1];
                up_tab[na][k] = (mid == '0) ? t_node'(0) : ancestor_at(mid, k - 1);
            end
            if (!is_loaded[na]) begin
                is_loaded[na] = 1'b1;
                loaded_list.insert(loaded_list.size(), na);
            end
        end
    endfunction

    // query: equalize depth, then binary search the meeting distance
    function automatic t_node predict_lca(t_node na, t_node nb);
        t_node deep;
        t_node shallow;
        int    lo;
        int    hi;
        int    mid;
        if (!node_in_range(na) || !node_in_range(nb)) return '0;
        deep    = na;
        shallow = nb;
        if (depth_of(na) < depth_of(nb)) begin
            deep    = nb;
            shallow = na;
        end
        deep = lift(deep, depth_of(deep) - depth_of(shallow));
        lo   = 0;
        hi   = depth_of(deep);
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (lift(deep, mid) == lift(shallow, mid)) hi = mid;
            else lo = mid + 1;
        end
        return lift(deep, hi);
    endfunction

    function automatic void tree_apply(logic fn, t_node na, t_node nb);
        t_pending p;
        if (fn == FUNC_LOAD) begin
            record_node(na, nb);
        end else begin
            p.node_a   = na;
            p.node_b   = nb;
            p.ancestor = predict_lca(na, nb);
            lca_expected.insert(lca_expected.size(), p);
        end
    endfunction

    // ---------------------------------------------------------------- node picking

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_node any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    function automatic t_node pick_fresh();
        t_node v;
        int    tries;
        v = t_node'($urandom_range(1, MAX_NODES));
        for (tries = 0; tries < 50 && is_loaded[v]; tries++)
            v = t_node'($urandom_range(1, MAX_NODES));
        return v;
    endfunction

    // often recent nodes so that chains grow deep, sometimes a new root
    function automatic t_node pick_parent();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = loaded_list.size();
        if (n == 0 || r < 15) return '0;
        if (r < 60) return loaded_list[n - 1 - $urandom_range(0, (n > 4) ? 3 : n - 1)];
        return any_loaded();
    endfunction

    function automatic t_node bad_node();
        if ($urandom_range(0, 3) == 0) return '0;
        return t_node'($urandom_range(MAX_NODES + 1, NODE_TOP));
    endfunction

    // ---------------------------------------------------------------- driving and checking

    task automatic flag_error(string what);
        if (err_count < 40) $display("ERROR at %0t: %s", $time, what);
        err_count++;
    endtask

    // offer one item and hold it until accepted
    task automatic send_item(logic fn, t_node na, t_node nb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_node_a   <= na;
        i_node_b   <= nb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tree_apply(fn, na, nb);
    endtask

    task automatic check_ancestor(t_node got);
        t_pending want;
        if (lca_expected.size() == 0) begin
            flag_error($sformatf("result with no query pending, ancestor=%0d", got));
        end else begin
            want = lca_expected.pop_front();
            if (got !== want.ancestor)
                flag_error($sformatf("query (%0d,%0d): ancestor %0d, predicted %0d",
                                     want.node_a, want.node_b, got, want.ancestor));
        end
    endtask

    // result side: check accepted items, random ready gaps, one long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) check_ancestor(o_ancestor);
        if (stall_req && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // ---------------------------------------------------------------- tests

    // bad nodes, ignored loads, small forest with separate trees
    task automatic test_directed();
        send_item(FUNC_QUERY, 11'd0, 11'd0);
        send_item(FUNC_QUERY, t_node'(NODE_TOP), t_node'(NODE_TOP));
        send_item(FUNC_LOAD, 11'd0, 11'd0);
        send_item(FUNC_LOAD, 11'd1025, 11'd5);
        send_item(FUNC_LOAD, 11'd7, 11'd1025);
        send_item(FUNC_LOAD, t_node'(NODE_TOP), t_node'(NODE_TOP));
        send_item(FUNC_LOAD, 11'd1, 11'd0);
        send_item(FUNC_LOAD, 11'd1024, 11'd0);
        send_item(FUNC_LOAD, 11'd2, 11'd1);
        send_item(FUNC_LOAD, 11'd3, 11'd1);
        send_item(FUNC_LOAD, 11'd4, 11'd2);
        send_item(FUNC_LOAD, 11'd1023, 11'd1024);
        send_item(FUNC_QUERY, 11'd4, 11'd3);
        send_item(FUNC_QUERY, 11'd4, 11'd4);
        send_item(FUNC_QUERY, 11'd2, 11'd4);
        send_item(FUNC_QUERY, 11'd4, 11'd1);
        send_item(FUNC_QUERY, 11'd1024, 11'd1023);
        send_item(FUNC_QUERY, 11'd4, 11'd1023);
        send_item(FUNC_QUERY, 11'd2, 11'd1023);
        send_item(FUNC_QUERY, 11'd1023, 11'd2);
        send_item(FUNC_QUERY, 11'd0, 11'd4);
        send_item(FUNC_QUERY, 11'd4, t_node'(NODE_TOP));
        send_item(FUNC_QUERY, 11'd1025, 11'd1);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(FUNC_QUERY, bad_node(), any_loaded());
            1: send_item(FUNC_QUERY, any_loaded(), bad_node());
            2: send_item(FUNC_LOAD, bad_node(), t_node'($urandom_range(0, NODE_TOP)));
            default: send_item(FUNC_LOAD, t_node'($urandom_range(1, MAX_NODES)),
                               t_node'($urandom_range(MAX_NODES + 1, NODE_TOP)));
        endcase
    endtask

    // growing forest: loads under loaded parents or as new roots, queries on loaded pairs, some noise
    task automatic test_random_forest();
        int    i;
        int    r;
        t_node na;
        t_node nb;
        for (i = 0; i < 200; i++) begin
            burst_mode = (i >= 80 && i < 120);
            r = $urandom_range(0, 99);
            if (loaded_list.size() < 2 || r < 40) begin
                na = ($urandom_range(0, 9) == 0) ? any_loaded() : pick_fresh();
                send_item(FUNC_LOAD, na, pick_parent());
            end else if (r < 93) begin
                na = any_loaded();
                nb = ($urandom_range(0, 9) == 0) ? na : any_loaded();
                send_item(FUNC_QUERY, na, nb);
            end else begin
                send_noise();
            end
        end
        burst_mode = 1'b0;
    endtask

    // receiver holds off while queries keep coming, so the engine backs up
    task automatic test_output_stall();
        int i;
        burst_mode = 1'b1;
        stall_req  = 1'b1;
        for (i = 0; i < 30; i++) send_item(FUNC_QUERY, any_loaded(), any_loaded());
        burst_mode = 1'b0;
    endtask

    // one long chain, long lifts, then loops made by re-parenting
    task automatic test_deep_chain();
        int i;
        send_item(FUNC_LOAD, 11'd1, 11'd0);
        for (i = 2; i <= CHAIN_LEN; i++) begin
            burst_mode = (i >= 250 && i < 350);
            send_item(FUNC_LOAD, t_node'(i), t_node'(i - 1));
        end
        burst_mode = 1'b0;
        send_item(FUNC_QUERY, t_node'(CHAIN_LEN), 11'd1);
        send_item(FUNC_QUERY, 11'd1, t_node'(CHAIN_LEN));
        send_item(FUNC_QUERY, t_node'(CHAIN_LEN), t_node'(CHAIN_LEN - 1));
        send_item(FUNC_QUERY, t_node'(CHAIN_LEN), 11'd300);
        send_item(FUNC_QUERY, 11'd500, 11'd200);
        for (i = 0; i < 35; i++)
            send_item(FUNC_QUERY, t_node'($urandom_range(1, CHAIN_LEN)),
                      t_node'($urandom_range(1, CHAIN_LEN)));
        // root moved under the chain end, so the chain closes into a loop
        send_item(FUNC_LOAD, 11'd1, t_node'(CHAIN_LEN));
        send_item(FUNC_QUERY, 11'd1, t_node'(CHAIN_LEN));
        send_item(FUNC_QUERY, 11'd1, 11'd2);
        send_item(FUNC_QUERY, 11'd1, 11'd500);
        send_item(FUNC_LOAD, t_node'(CHAIN_LEN), t_node'(CHAIN_LEN));
        send_item(FUNC_QUERY, t_node'(CHAIN_LEN), 11'd500);
        send_item(FUNC_QUERY, t_node'(CHAIN_LEN), 11'd1);
        send_item(FUNC_QUERY, 11'd3, t_node'(CHAIN_LEN));
        for (i = 0; i < 10; i++)
            send_item(FUNC_QUERY, t_node'($urandom_range(1, CHAIN_LEN)),
                      t_node'($urandom_range(1, CHAIN_LEN)));
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_LOAD;
        i_node_a    = '0;
        i_node_b    = '0;
        err_count   = 0;
        burst_mode  = 1'b0;
        stall_req   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_forest();
        test_output_stall();
        test_deep_chain();

        // drain outstanding queries, then report the result
        i_in_valid <= 1'b0;
        while (lca_expected.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard
    initial begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
